// ===== rtl/qrn_pkg.sv =====
// Shared widths, stage counts and types for the quaternion renormalize pipeline.
// No dependencies.
package qrn_pkg;
	localparam int CW = 32;
	localparam int FB = 29;
	localparam int TOL_W = 30;
	localparam int SUM_W = 2 * CW + 2;
	localparam int ROOT_W = CW + 1;
	localparam int REM_W = ROOT_W + 3;
	localparam int Q_W = FB + 1;
	localparam int DR_W = ROOT_W + 1;
	localparam int SQRT_N = ROOT_W;
	localparam int DIV_N = Q_W;
	localparam int LATENCY = SQRT_N + DIV_N + 5;
	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(5368709);
	localparam logic [ROOT_W-1:0] ONE_Q = ROOT_W'(1) << FB;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic [CW-1:0] mag_t;

	typedef struct packed {
		comp_t [3:0] raw;
		mag_t [3:0] mag;
	} item_t;

	typedef struct packed {
		comp_t [3:0] raw;
		logic renorm;
		logic zero;
	} res_t;
endpackage

// ===== rtl/qrn_sqrt_cell.sv =====
// One bit of the restoring integer square root: takes two radicand bits, emits one root bit.
// Depends on qrn_pkg.
module qrn_sqrt_cell (
	input  logic                        clk,
	input  logic [qrn_pkg::SUM_W-1:0]   rad_in,
	input  logic [qrn_pkg::REM_W-1:0]   rem_in,
	input  logic [qrn_pkg::ROOT_W-1:0]  root_in,
	output logic [qrn_pkg::SUM_W-1:0]   rad_out,
	output logic [qrn_pkg::REM_W-1:0]   rem_out,
	output logic [qrn_pkg::ROOT_W-1:0]  root_out
);
	import qrn_pkg::*;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             ge;

	assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
	assign trial  = REM_W'({root_in, 2'b01});
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk) begin
		rad_out  <= {rad_in[SUM_W-3:0], 2'b00};
		rem_out  <= ge ? rem_sh - trial : rem_sh;
		root_out <= {root_in[ROOT_W-2:0], ge};
	end
endmodule

// ===== rtl/qrn_div_cell.sv =====
// One quotient bit of the restoring divider: compare, subtract, shift.
// Depends on qrn_pkg.
module qrn_div_cell (
	input  logic                        clk,
	input  logic [qrn_pkg::DR_W-1:0]    r_in,
	input  logic [qrn_pkg::ROOT_W-1:0]  d_in,
	input  logic [qrn_pkg::Q_W-1:0]     q_in,
	output logic [qrn_pkg::DR_W-1:0]    r_out,
	output logic [qrn_pkg::ROOT_W-1:0]  d_out,
	output logic [qrn_pkg::Q_W-1:0]     q_out
);
	import qrn_pkg::*;

	logic [DR_W-1:0] rs;
	logic            ge;

	assign ge = r_in >= DR_W'(d_in);
	assign rs = ge ? r_in - DR_W'(d_in) : r_in;

	always_ff @(posedge clk) begin
		r_out <= {rs[DR_W-2:0], 1'b0};
		d_out <= d_in;
		q_out <= {q_in[Q_W-2:0], ge};
	end
endmodule

// ===== rtl/quaternion_renormalize.sv =====
// Quaternion renormalize: squares, sum, square root chain, tolerance check, divider chains.
// Depends on qrn_pkg, qrn_sqrt_cell, qrn_div_cell.
// Path from start to done: 5 registers, 33 root cells and 30 quotient cells.
// Throughput: one quaternion per cycle; busy stays low, so start may be high every cycle.
// The receiver cannot stall; each result shows for one cycle with done.
// Reset clears the valid chain and sets tolerance to about 0.01; datapath is not reset.
module quaternion_renormalize (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [qrn_pkg::CW-1:0] in_w,
	input  logic signed [qrn_pkg::CW-1:0] in_x,
	input  logic signed [qrn_pkg::CW-1:0] in_y,
	input  logic signed [qrn_pkg::CW-1:0] in_z,
	input  logic                        tol_we,
	input  logic [qrn_pkg::TOL_W-1:0]   tol_wdata,
	output logic                        done,
	output logic signed [qrn_pkg::CW-1:0] out_w,
	output logic signed [qrn_pkg::CW-1:0] out_x,
	output logic signed [qrn_pkg::CW-1:0] out_y,
	output logic signed [qrn_pkg::CW-1:0] out_z,
	output logic                        renormalized,
	output logic                        zero_norm
);
	import qrn_pkg::*;

	logic [TOL_W-1:0] tol_q;
	logic [LATENCY-2:0] vld_q;

	comp_t [3:0] raw_in;
	item_t item_s1, item_s2;
	logic [2*CW-1:0] sq_s2 [4];
	logic [SUM_W-1:0] sum_s3;
	item_t item_s3;

	logic [SUM_W-1:0]  rad_c  [SQRT_N+1];
	logic [REM_W-1:0]  rem_c  [SQRT_N+1];
	logic [ROOT_W-1:0] root_c [SQRT_N+1];
	item_t             sit_q  [SQRT_N+1];

	logic [ROOT_W-1:0] root_s4;
	logic [ROOT_W-1:0] dev;
	res_t res_s4;
	item_t item_s4;

	logic [DR_W-1:0]   r_c [4][DIV_N+1];
	logic [ROOT_W-1:0] d_c [4][DIV_N+1];
	logic [Q_W-1:0]    q_c [4][DIV_N+1];
	res_t              dres_q [DIV_N+1];
	comp_t [3:0]       quo;

	assign busy   = 1'b0;
	assign raw_in = {in_z, in_y, in_x, in_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			vld_q <= '0;
		end else begin
			if (tol_we) tol_q <= tol_wdata;
			vld_q <= {vld_q[LATENCY-3:0], start};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			item_s1.raw[i] <= raw_in[i];
			item_s1.mag[i] <= raw_in[i][CW-1] ? mag_t'(-raw_in[i]) : mag_t'(raw_in[i]);
			sq_s2[i] <= (2*CW)'(item_s1.mag[i]) * (2*CW)'(item_s1.mag[i]);
		end
		item_s2 <= item_s1;
		sum_s3  <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]) + SUM_W'(sq_s2[3]);
		item_s3 <= item_s2;
	end

	assign rad_c[0]  = sum_s3;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign sit_q[0]  = item_s3;

	for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
		qrn_sqrt_cell u_cell (
			.clk      (clk),
			.rad_in   (rad_c[k]),
			.rem_in   (rem_c[k]),
			.root_in  (root_c[k]),
			.rad_out  (rad_c[k+1]),
			.rem_out  (rem_c[k+1]),
			.root_out (root_c[k+1])
		);
		always_ff @(posedge clk) sit_q[k+1] <= sit_q[k];
	end

	assign dev = (root_c[SQRT_N] >= ONE_Q) ? root_c[SQRT_N] - ONE_Q
		: ONE_Q - root_c[SQRT_N];

	always_ff @(posedge clk) begin
		root_s4       <= root_c[SQRT_N];
		item_s4       <= sit_q[SQRT_N];
		res_s4.raw    <= sit_q[SQRT_N].raw;
		res_s4.zero   <= root_c[SQRT_N] == '0;
		res_s4.renorm <= (root_c[SQRT_N] != '0) && (dev >= ROOT_W'(tol_q));
	end

	assign dres_q[0] = res_s4;

	for (genvar l = 0; l < 4; l++) begin : g_lane
		assign r_c[l][0] = DR_W'(item_s4.mag[l]);
		assign d_c[l][0] = root_s4;
		assign q_c[l][0] = '0;
		for (genvar k = 0; k < DIV_N; k++) begin : g_div
			qrn_div_cell u_cell (
				.clk   (clk),
				.r_in  (r_c[l][k]),
				.d_in  (d_c[l][k]),
				.q_in  (q_c[l][k]),
				.r_out (r_c[l][k+1]),
				.d_out (d_c[l][k+1]),
				.q_out (q_c[l][k+1])
			);
		end
		assign quo[l] = dres_q[DIV_N].raw[l][CW-1] ? -comp_t'(q_c[l][DIV_N])
			: comp_t'(q_c[l][DIV_N]);
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_dres
		always_ff @(posedge clk) dres_q[k+1] <= dres_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[LATENCY-2];
		end
	end

	always_ff @(posedge clk) begin
		out_w        <= dres_q[DIV_N].renorm ? quo[0] : dres_q[DIV_N].raw[0];
		out_x        <= dres_q[DIV_N].renorm ? quo[1] : dres_q[DIV_N].raw[1];
		out_y        <= dres_q[DIV_N].renorm ? quo[2] : dres_q[DIV_N].raw[2];
		out_z        <= dres_q[DIV_N].renorm ? quo[3] : dres_q[DIV_N].raw[3];
		renormalized <= dres_q[DIV_N].renorm;
		zero_norm    <= dres_q[DIV_N].zero;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done) else $error("result word missing");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(renormalized && zero_norm)) else $error("conflicting flags");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_norm) |-> (out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0))
		else $error("zero magnitude with nonzero word");
	a_quo: assert property (@(posedge clk) disable iff (!arst_n)
		(done && renormalized) |-> (out_w <= $signed(CW'(ONE_Q))
			&& out_w >= -$signed(CW'(ONE_Q)))) else $error("quotient out of range");
endmodule

// ===== tb/sv/quaternion_renormalize_test.sv =====
// Self-checking bench for quaternion_renormalize: random and directed quaternions,
// tolerance sweeps, per-field compare against a built-in renormalize predictor.
// Depends on qrn_pkg and the quaternion_renormalize RTL.
class renorm_scoreboard;
	typedef struct {
		logic [31:0] c [4];
		logic renorm;
		logic zero;
	} quat_word_t;

	quat_word_t pending[$];
	logic [29:0] tol;
	int errors;
	int checked;
	int renorm_seen;
	int zero_seen;

	function void set_tolerance(logic [29:0] t);
		tol = t;
	endfunction

	function void note_input(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		quat_word_t e;
		logic [31:0] raw [4];
		logic [31:0] mag [4];
		logic [65:0] sum;
		logic [65:0] sq;
		logic [32:0] root;
		logic [32:0] cand;
		logic [32:0] dev;
		logic [32:0] one;
		logic [63:0] q;
		logic [31:0] v;
		raw[0] = w; raw[1] = x; raw[2] = y; raw[3] = z;
		sum = '0;
		for (int i = 0; i < 4; i++) begin
			mag[i] = raw[i][31] ? (32'd0 - raw[i]) : raw[i];
			sum += 66'(mag[i]) * 66'(mag[i]);
		end
		root = '0;
		for (int b = 32; b >= 0; b--) begin
			cand = root | (33'd1 << b);
			sq = 66'(cand) * 66'(cand);
			if (sq <= sum)
				root = cand;
		end
		e.renorm = 1'b0;
		e.zero = 1'b0;
		for (int i = 0; i < 4; i++)
			e.c[i] = raw[i];
		one = 33'd1 << 29;
		if (root == 0) begin
			e.zero = 1'b1;
		end else begin
			dev = (root >= one) ? root - one : one - root;
			if (dev >= 33'(tol)) begin
				e.renorm = 1'b1;
				for (int i = 0; i < 4; i++) begin
					q = (64'(mag[i]) << 29) / 64'(root);
					if (raw[i][31])
						v = (q > 64'h8000_0000) ? 32'h8000_0000 : q[31:0];
					else
						v = (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
					e.c[i] = raw[i][31] ? (32'd0 - v) : v;
				end
			end
		end
		pending.push_back(e);
	endfunction

	function void check_result(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic rn, logic zn);
		quat_word_t e;
		logic [31:0] got [4];
		string names [4];
		if (pending.size() == 0) begin
			$error("result word with no input pending");
			errors++;
			return;
		end
		e = pending.pop_front();
		got[0] = w; got[1] = x; got[2] = y; got[3] = z;
		names = '{"out_w", "out_x", "out_y", "out_z"};
		checked++;
		if (e.renorm) renorm_seen++;
		if (e.zero) zero_seen++;
		for (int i = 0; i < 4; i++)
			if (got[i] !== e.c[i]) begin
				$error("%s expected %h actual %h", names[i], e.c[i], got[i]);
				errors++;
			end
		if (rn !== e.renorm) begin
			$error("renormalized expected %b actual %b", e.renorm, rn);
			errors++;
		end
		if (zn !== e.zero) begin
			$error("zero_norm expected %b actual %b", e.zero, zn);
			errors++;
		end
	endfunction
endclass

module quaternion_renormalize_test;
	import qrn_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CW-1:0] in_w = '0, in_x = '0, in_y = '0, in_z = '0;
	logic tol_we = 1'b0;
	logic [TOL_W-1:0] tol_wdata = '0;
	logic done;
	logic signed [CW-1:0] out_w, out_x, out_y, out_z;
	logic renormalized, zero_norm;

	renorm_scoreboard board;
	int items_sent;

	quaternion_renormalize DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_w(in_w), .in_x(in_x), .in_y(in_y), .in_z(in_z),
		.tol_we(tol_we), .tol_wdata(tol_wdata), .done(done),
		.out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.renormalized(renormalized), .zero_norm(zero_norm)
	);

	always #1 clk = ~clk;

	always @(posedge clk)
		if (arst_n && done)
			board.check_result(out_w, out_x, out_y, out_z, renormalized, zero_norm);

	task automatic send_quat(logic [31:0] w, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit idle);
		int gap;
		gap = idle ? $urandom_range(17, 0) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_w <= w; in_x <= x; in_y <= y; in_z <= z;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_input(w, x, y, z);
		items_sent++;
	endtask

	task automatic drain;
		start <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [29:0] t);
		drain();
		tol_we <= 1'b1;
		tol_wdata <= t;
		@(posedge clk);
		tol_we <= 1'b0;
		board.set_tolerance(t);
	endtask

	function automatic logic [31:0] rand_comp(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(600000000, 0)) - 300000000);
			default: return 32'($signed($urandom_range(40000, 0)) - 20000);
		endcase
	endfunction

	task automatic random_phase(int n, bit idle);
		int mode;
		for (int k = 0; k < n; k++) begin
			mode = $urandom_range(2, 0);
			if ($urandom_range(9, 0) == 0)
				send_quat(32'h2000_0000 + $urandom_range(20000, 0) - 10000, 0, 0, 0, idle);
			else if ($urandom_range(29, 0) == 0)
				send_quat(0, 0, 0, 0, idle);
			else
				send_quat(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode),
					idle);
		end
	endtask

	initial begin
		board = new();
		board.set_tolerance(TOL_RESET);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_quat(0, 0, 0, 0, 0);
		send_quat(32'h2000_0000, 0, 0, 0, 0);
		send_quat(0, 32'he000_0000, 0, 0, 0);
		send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		send_quat(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0);
		send_quat(1, 0, 0, 0, 0);
		send_quat(32'hffff_ffff, 1, 32'hffff_ffff, 1, 0);
		send_quat(32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 0);
		send_quat(32'h2000_0000 + 5368709, 0, 0, 0, 0);
		send_quat(32'h2000_0000 + 5368708, 0, 0, 0, 0);
		send_quat(32'h2000_0000 - 5368709, 0, 0, 0, 0);
		send_quat(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 0);
		random_phase(200, 1);

		write_tolerance(30'd0);
		send_quat(32'h2000_0000, 0, 0, 0, 0);
		send_quat(0, 0, 0, 0, 0);
		random_phase(150, 1);

		write_tolerance(30'h3fff_ffff);
		send_quat(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
		random_phase(150, 0);

		write_tolerance(30'h2000_0000);
		random_phase(150, 1);

		write_tolerance(30'($urandom_range(1000000, 0)));
		random_phase(150, 1);

		write_tolerance(TOL_RESET);
		random_phase(100, 0);

		drain();
		$display("Sent %0d quaternions over six tolerance settings; %0d renormalized, %0d zero.",
			items_sent, board.renorm_seen, board.zero_seen);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#200000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
